### rtl/core/qalu_pkg.sv
package qalu_pkg;

  localparam int COMP_WIDTH = 16;
  localparam int FRAC_BITS  = 14;
  localparam int OPC_W      = 4;
  localparam int LANES      = 4;
  localparam int TERMS      = 4;

  localparam logic [OPC_W-1:0] OP_ADD      = 4'd0;
  localparam logic [OPC_W-1:0] OP_SUB      = 4'd1;
  localparam logic [OPC_W-1:0] OP_MUL      = 4'd2;
  localparam logic [OPC_W-1:0] OP_MUL_CONJ = 4'd3;
  localparam logic [OPC_W-1:0] OP_CONJ     = 4'd4;
  localparam logic [OPC_W-1:0] OP_NEG      = 4'd5;
  localparam logic [OPC_W-1:0] OP_SCALE    = 4'd6;
  localparam logic [OPC_W-1:0] OP_MIX      = 4'd7;
  localparam logic [OPC_W-1:0] OP_ADDR     = 4'd8;
  localparam logic [OPC_W-1:0] OP_SUBR     = 4'd9;
  localparam logic [OPC_W-1:0] OP_RSUBR    = 4'd10;
  localparam logic [OPC_W-1:0] OP_NORMSQ   = 4'd11;

  // Hamilton product: lane i, term k uses a[i^k] * b[k]; set bits subtract the term.
  localparam logic [TERMS-1:0] HAM_NEG [LANES] = '{4'b1110, 4'b0100, 4'b1000, 4'b0010};
  // Conjugating b flips every term that uses an imaginary part of b.
  localparam logic [TERMS-1:0] CONJ_FLIP = 4'b1110;

  typedef struct packed {
    logic [TERMS-1:0] neg;
    logic             shift;
  } lane_ctl_t;

endpackage

### rtl/core/qalu_in_if.sv
interface qalu_in_if #(
  parameter int W = qalu_pkg::COMP_WIDTH
);
  logic                       valid;
  logic                       ready;
  logic [qalu_pkg::OPC_W-1:0] opcode;
  logic signed [W-1:0]        a_w;
  logic signed [W-1:0]        a_x;
  logic signed [W-1:0]        a_y;
  logic signed [W-1:0]        a_z;
  logic signed [W-1:0]        b_w;
  logic signed [W-1:0]        b_x;
  logic signed [W-1:0]        b_y;
  logic signed [W-1:0]        b_z;
  logic signed [W-1:0]        scalar;

  modport source (
    output valid, opcode, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z, scalar,
    input  ready
  );
  modport sink (
    input  valid, opcode, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z, scalar,
    output ready
  );
endinterface

### rtl/core/qalu_out_if.sv
interface qalu_out_if #(
  parameter int W = qalu_pkg::COMP_WIDTH
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] r_w;
  logic signed [W-1:0] r_x;
  logic signed [W-1:0] r_y;
  logic signed [W-1:0] r_z;
  logic                saturated;

  modport source (
    output valid, r_w, r_x, r_y, r_z, saturated,
    input  ready
  );
  modport sink (
    input  valid, r_w, r_x, r_y, r_z, saturated,
    output ready
  );
endinterface

### rtl/core/quaternion_alu_unit.sv
// channel | direction | payload
// in_ch   | sink      | opcode, a_w..a_z, b_w..b_z, scalar
// out_ch  | source    | r_w, r_x, r_y, r_z, saturated
//
// The pipeline stages, in order: operand decode, lane multiply, lane sum/shift/saturate.
// One item per cycle while the output is not stalled; four lanes, each with four multipliers, run side by side.
// rst_n clears the stage valid bits only; the data path needs no reset.
// A stalled output freezes the whole pipe and drops in_ch.ready.
module quaternion_alu_unit #(
  parameter int COMP_WIDTH = qalu_pkg::COMP_WIDTH,
  parameter int FRAC_BITS  = qalu_pkg::FRAC_BITS
) (
  input  logic     clk,
  input  logic     rst_n,
  qalu_in_if.sink  in_ch,
  qalu_out_if.source out_ch
);

  localparam int W  = COMP_WIDTH;
  localparam int YW = ((FRAC_BITS + 2) > (W + 1)) ? (FRAC_BITS + 2) : (W + 1);

  logic                adv;
  logic                v1_r;
  logic                v2_r;
  logic                v3_r;
  logic [3:0][W-1:0]   a_pk;
  logic [3:0][W-1:0]   b_pk;
  logic [3:0][W-1:0]   x_r   [qalu_pkg::LANES];
  logic [3:0][YW-1:0]  y_r   [qalu_pkg::LANES];
  qalu_pkg::lane_ctl_t ctl_r [qalu_pkg::LANES];
  logic [W-1:0]        res   [qalu_pkg::LANES];
  logic [qalu_pkg::LANES-1:0] sat;

  assign adv         = !v3_r || out_ch.ready;
  assign in_ch.ready = adv;

  assign a_pk = {in_ch.a_z, in_ch.a_y, in_ch.a_x, in_ch.a_w};
  assign b_pk = {in_ch.b_z, in_ch.b_y, in_ch.b_x, in_ch.b_w};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_ch.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  qalu_decode #(
    .W  (W),
    .F  (FRAC_BITS),
    .YW (YW)
  ) u_decode (
    .clk    (clk),
    .en     (adv),
    .opcode (in_ch.opcode),
    .a      (a_pk),
    .b      (b_pk),
    .scalar (in_ch.scalar),
    .x_r    (x_r),
    .y_r    (y_r),
    .ctl_r  (ctl_r)
  );

  for (genvar i = 0; i < qalu_pkg::LANES; i++) begin : g_lane
    qalu_lane #(
      .W  (W),
      .F  (FRAC_BITS),
      .YW (YW)
    ) u_lane (
      .clk   (clk),
      .en    (adv),
      .x     (x_r[i]),
      .y     (y_r[i]),
      .ctl   (ctl_r[i]),
      .res_r (res[i]),
      .sat_r (sat[i])
    );
  end

  assign out_ch.valid     = v3_r;
  assign out_ch.r_w       = res[0];
  assign out_ch.r_x       = res[1];
  assign out_ch.r_y       = res[2];
  assign out_ch.r_z       = res[3];
  assign out_ch.saturated = |sat;

endmodule

### rtl/core/qalu_decode.sv
module qalu_decode #(
  parameter int W  = qalu_pkg::COMP_WIDTH,
  parameter int F  = qalu_pkg::FRAC_BITS,
  parameter int YW = W + 1
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic [qalu_pkg::OPC_W-1:0] opcode,
  input  logic [3:0][W-1:0]          a,
  input  logic [3:0][W-1:0]          b,
  input  logic [W-1:0]               scalar,
  output logic [3:0][W-1:0]          x_r   [qalu_pkg::LANES],
  output logic [3:0][YW-1:0]         y_r   [qalu_pkg::LANES],
  output qalu_pkg::lane_ctl_t        ctl_r [qalu_pkg::LANES]
);

  localparam logic [YW-1:0] ONE_Y  = YW'(1);
  localparam logic [YW-1:0] ONE_FX = ONE_Y << F;

  logic [3:0][W-1:0]   x_nxt   [qalu_pkg::LANES];
  logic [3:0][YW-1:0]  y_nxt   [qalu_pkg::LANES];
  qalu_pkg::lane_ctl_t ctl_nxt [qalu_pkg::LANES];
  logic [3:0][YW-1:0]  b_y;
  logic [YW-1:0]       s_y;
  logic [YW-1:0]       d_y;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      b_y[k] = {{(YW-W){b[k][W-1]}}, b[k]};
    end
    s_y = {{(YW-W){scalar[W-1]}}, scalar};
    d_y = ONE_FX - s_y;
  end

  always_comb begin
    for (int i = 0; i < qalu_pkg::LANES; i++) begin
      x_nxt[i]   = '0;
      y_nxt[i]   = '0;
      ctl_nxt[i] = '{neg: '0, shift: 1'b0};
    end
    case (opcode)
      qalu_pkg::OP_ADD, qalu_pkg::OP_SUB: begin
        for (int i = 0; i < qalu_pkg::LANES; i++) begin
          x_nxt[i][0] = a[i];
          y_nxt[i][0] = ONE_Y;
          x_nxt[i][1] = b[i];
          y_nxt[i][1] = ONE_Y;
          ctl_nxt[i].neg[1] = (opcode == qalu_pkg::OP_SUB);
        end
      end
      qalu_pkg::OP_MUL, qalu_pkg::OP_MUL_CONJ: begin
        for (int i = 0; i < qalu_pkg::LANES; i++) begin
          for (int k = 0; k < qalu_pkg::TERMS; k++) begin
            x_nxt[i][k] = a[i ^ k];
            y_nxt[i][k] = b_y[k];
          end
          ctl_nxt[i].neg   = (opcode == qalu_pkg::OP_MUL_CONJ)
                             ? (qalu_pkg::HAM_NEG[i] ^ qalu_pkg::CONJ_FLIP)
                             : qalu_pkg::HAM_NEG[i];
          ctl_nxt[i].shift = 1'b1;
        end
      end
      qalu_pkg::OP_CONJ, qalu_pkg::OP_NEG: begin
        for (int i = 0; i < qalu_pkg::LANES; i++) begin
          x_nxt[i][0] = a[i];
          y_nxt[i][0] = ONE_Y;
          ctl_nxt[i].neg[0] = (i != 0) || (opcode == qalu_pkg::OP_NEG);
        end
      end
      qalu_pkg::OP_SCALE: begin
        for (int i = 0; i < qalu_pkg::LANES; i++) begin
          x_nxt[i][0] = a[i];
          y_nxt[i][0] = s_y;
          ctl_nxt[i].shift = 1'b1;
        end
      end
      qalu_pkg::OP_MIX: begin
        for (int i = 0; i < qalu_pkg::LANES; i++) begin
          x_nxt[i][0] = a[i];
          y_nxt[i][0] = d_y;
          x_nxt[i][1] = b[i];
          y_nxt[i][1] = s_y;
          ctl_nxt[i].shift = 1'b1;
        end
      end
      qalu_pkg::OP_ADDR, qalu_pkg::OP_SUBR, qalu_pkg::OP_RSUBR: begin
        for (int i = 0; i < qalu_pkg::LANES; i++) begin
          x_nxt[i][0] = a[i];
          y_nxt[i][0] = ONE_Y;
          ctl_nxt[i].neg[0] = (opcode == qalu_pkg::OP_RSUBR);
        end
        x_nxt[0][1] = scalar;
        y_nxt[0][1] = ONE_Y;
        ctl_nxt[0].neg[1] = (opcode == qalu_pkg::OP_SUBR);
      end
      qalu_pkg::OP_NORMSQ: begin
        for (int k = 0; k < qalu_pkg::TERMS; k++) begin
          x_nxt[0][k] = a[k];
          y_nxt[0][k] = {{(YW-W){a[k][W-1]}}, a[k]};
        end
        for (int i = 0; i < qalu_pkg::LANES; i++) begin
          ctl_nxt[i].shift = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r   <= x_nxt;
      y_r   <= y_nxt;
      ctl_r <= ctl_nxt;
    end
  end

endmodule

### rtl/core/qalu_lane.sv
module qalu_lane #(
  parameter int W  = qalu_pkg::COMP_WIDTH,
  parameter int F  = qalu_pkg::FRAC_BITS,
  parameter int YW = W + 1
) (
  input  logic                clk,
  input  logic                en,
  input  logic [3:0][W-1:0]   x,
  input  logic [3:0][YW-1:0]  y,
  input  qalu_pkg::lane_ctl_t ctl,
  output logic [W-1:0]        res_r,
  output logic                sat_r
);

  localparam int PW = W + YW;
  localparam int AW = PW + 2;

  logic signed [PW-1:0] prod_r [qalu_pkg::TERMS];
  qalu_pkg::lane_ctl_t  ctl_r;
  logic signed [AW-1:0] term;
  logic signed [AW-1:0] sum;
  logic signed [AW-1:0] shifted;
  logic [AW-W:0]        upper;
  logic                 ovf;
  logic [W-1:0]         res_nxt;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < qalu_pkg::TERMS; k++) begin
        prod_r[k] <= PW'($signed(x[k])) * PW'($signed(y[k]));
      end
      ctl_r <= ctl;
    end
  end

  always_comb begin
    sum  = '0;
    term = '0;
    for (int k = 0; k < qalu_pkg::TERMS; k++) begin
      term = AW'(prod_r[k]);
      sum  = ctl_r.neg[k] ? (sum - term) : (sum + term);
    end
    shifted = ctl_r.shift ? (sum >>> F) : sum;
    upper   = shifted[AW-1:W-1];
    ovf     = !((&upper) || (~|upper));
    if (ovf) begin
      res_nxt = shifted[AW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    end else begin
      res_nxt = shifted[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
      sat_r <= ovf;
    end
  end

endmodule
